// ===== rtl/core/hdu_pkg.sv =====
// ============================================================================
// hdu_pkg: shared types and constants for the half-duplex 8N1 UART
// Word formats for both channels, the command classes passed from the front
// queue to the engine, queue control bundles and register map constants.
// ============================================================================
`default_nettype none

package hdu_pkg;

    // Command codes as they arrive on the input channel
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_TAKE = 2'd2;

    // Register map (word index from paddr[2])
    localparam int         PADDR_W          = 3;
    localparam logic       REG_BIT_PERIOD   = 1'b0;
    localparam logic       REG_START_OFFSET = 1'b1;
    localparam logic [15:0] RESET_BIT_PERIOD   = 16'd104;
    localparam logic [15:0] RESET_START_OFFSET = 16'd52;

    // Frame shape: start + 8 data + stop sampled on receive,
    // 8 data + stop shifted out after the start bit on transmit
    localparam logic [3:0] RX_FRAME_BITS = 4'd10;
    localparam logic [3:0] TX_SHIFT_BITS = 4'd9;

    // Classified command handed from the front to the engine
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    // Input channel word
    typedef struct packed {
        logic [1:0] cmd;
        logic       rx_line;
        logic [7:0] tx_byte;
    } in_word_t;

    // Result channel word
    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_accepted;
        logic       rx_overrun;
        logic [4:0] rx_waiting;
        logic [4:0] tx_pending;
        logic       receiving;
        logic       transmitting;
    } out_word_t;

    // Word held in the command queue between front and engine
    typedef struct packed {
        op_t        op;
        logic       rx_line;
        logic [7:0] tx_byte;
    } cmd_word_t;

    // Byte queue control from the engine
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } q_ctl_t;

    // Byte queue status to the engine
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/hdu_front.sv =====
// ============================================================================
// hdu_front: command intake
// Classifies each input word and holds it in a two-entry queue so the engine
// can stall independently of the input channel.
// ============================================================================
`default_nettype none

module hdu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire hdu_pkg::in_word_t  in_data,
    output logic                    cmd_valid,
    output hdu_pkg::cmd_word_t      cmd_word,
    input  wire logic               cmd_pop
);
    import hdu_pkg::*;

    cmd_word_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    cmd_word_t   classified;

    // Decode the command into an operation class
    always_comb
    begin
        classified.rx_line = in_data.rx_line;
        classified.tx_byte = in_data.tx_byte;
        unique case (in_data.cmd)
            CMD_TICK: classified.op = OP_TICK;
            CMD_SEND: classified.op = OP_PUSH;
            CMD_TAKE: classified.op = OP_POP;
            default:  classified.op = OP_NOP;
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd_word  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push    ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hdu_byte_q.sv =====
// ============================================================================
// hdu_byte_q: byte queue
// Circular buffer in a memory with one write and one registered read port.
// Pop loads the head byte into the read register at the same edge.
// ============================================================================
`default_nettype none

module hdu_byte_q #(
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hdu_pkg::q_ctl_t              ctl,
    output logic [7:0]                        rd_data,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    output hdu_pkg::q_stat_t                  stat
);
    import hdu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign rd_data    = rd_data_reg;
    assign count      = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

    // Pointer wrap and fill count; push and pop together leave the count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + CW'(ctl.push) - CW'(ctl.pop);
        if (ctl.push)
        begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= ctl.data;
        end
    end

    // Memory read port, registered
    always_ff @(posedge clk)
    begin
        if (ctl.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hdu_engine.sv =====
// ============================================================================
// hdu_engine: UART bit engine
// Executes one classified command per cycle while the result slot is free
// or draining: bit timer, receive sampler, transmit shifter, queue pushes
// and pops, and the result word register.
`default_nettype none

module hdu_engine #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [15:0]                       bit_period,
    input  wire logic [15:0]                       start_offset,
    input  wire logic                              cmd_valid,
    input  wire hdu_pkg::cmd_word_t                cmd_word,
    output logic                                   cmd_pop,
    output hdu_pkg::q_ctl_t                        tx_ctl,
    input  wire logic [7:0]                        tx_rd_data,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]  tx_count,
    input  wire hdu_pkg::q_stat_t                  tx_stat,
    output hdu_pkg::q_ctl_t                        rx_ctl,
    input  wire logic [7:0]                        rx_rd_data,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]  rx_count,
    input  wire hdu_pkg::q_stat_t                  rx_stat,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output hdu_pkg::out_word_t                     out_data
);
    import hdu_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Line and mode state
    logic        mode_rx_reg,   mode_rx_next;
    logic        mode_tx_reg,   mode_tx_next;
    logic        line_out_reg,  line_out_next;
    logic        last_rx_reg,   last_rx_next;
    logic [15:0] tick_cnt_reg,  tick_cnt_next;
    logic [9:0]  rx_shift_reg,  rx_shift_next;
    logic [3:0]  rx_left_reg,   rx_left_next;
    logic [8:0]  tx_shift_reg,  tx_shift_next;
    logic [3:0]  tx_left_reg,   tx_left_next;
    logic        tx_fill_reg,   tx_fill_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   res_reg,       res_next;

    logic          fire;
    logic          was_idle;
    logic          timer_done;
    logic          accepted;
    logic          overrun;
    logic          rx_got;
    logic [8:0]    tx_sh_cur;
    logic [CW-1:0] rx_cnt_post;
    logic [CW-1:0] tx_cnt_post;
    logic [31:0]   rx_cnt_wide;
    logic [31:0]   tx_cnt_wide;

    // One command per cycle whenever the result slot is free or draining
    assign fire       = cmd_valid && (!out_valid_reg || !out_stall);
    assign cmd_pop    = fire;
    assign was_idle   = !mode_rx_reg && !mode_tx_reg;
    assign timer_done = (tick_cnt_reg <= 16'd1);

    // Byte fetched at transmit start arrives from the memory read register in the next cycle
    assign tx_sh_cur = tx_fill_reg ? {1'b1, tx_rd_data} : tx_shift_reg;

    // Command execution
    always_comb
    begin
        mode_rx_next  = mode_rx_reg;
        mode_tx_next  = mode_tx_reg;
        line_out_next = line_out_reg;
        last_rx_next  = last_rx_reg;
        tick_cnt_next = tick_cnt_reg;
        rx_shift_next = rx_shift_reg;
        rx_left_next  = rx_left_reg;
        tx_shift_next = tx_sh_cur;
        tx_left_next  = tx_left_reg;
        tx_fill_next  = tx_fill_reg;
        tx_ctl        = '0;
        rx_ctl        = '0;
        accepted      = 1'b0;
        overrun       = 1'b0;
        rx_got        = 1'b0;
        tx_ctl.data   = cmd_word.tx_byte;
        rx_ctl.data   = rx_shift_next[8:1];

        if (fire)
        begin
            tx_fill_next = 1'b0;
            unique case (cmd_word.op)
                OP_TICK:
                begin
                    // Receive sampler
                    if (mode_rx_reg)
                    begin
                        if (timer_done)
                        begin
                            rx_shift_next = {cmd_word.rx_line, rx_shift_reg[9:1]};
                            rx_left_next  = rx_left_reg - 4'd1;
                            tick_cnt_next = bit_period;
                            if (rx_left_next == 4'd0)
                            begin
                                mode_rx_next  = 1'b0;
                                tick_cnt_next = 16'd0;
                                // Keep frame only with low start and high stop
                                if (!rx_shift_next[0] && rx_shift_next[9])
                                begin
                                    if (rx_stat.full)
                                    begin
                                        overrun = 1'b1;
                                    end
                                    else
                                    begin
                                        rx_ctl.push = 1'b1;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            tick_cnt_next = tick_cnt_reg - 16'd1;
                        end
                    end
                    // Transmit shifter
                    else if (mode_tx_reg)
                    begin
                        if (timer_done)
                        begin
                            if (tx_left_reg != 4'd0)
                            begin
                                line_out_next = tx_sh_cur[0];
                                tx_shift_next = {1'b0, tx_sh_cur[8:1]};
                                tx_left_next  = tx_left_reg - 4'd1;
                                tick_cnt_next = bit_period;
                            end
                            else
                            begin
                                mode_tx_next  = 1'b0;
                                line_out_next = 1'b1;
                                tick_cnt_next = 16'd0;
                            end
                        end
                        else
                        begin
                            tick_cnt_next = tick_cnt_reg - 16'd1;
                        end
                    end

                    // Idle: start edge wins over a queued byte
                    if (was_idle)
                    begin
                        if (last_rx_reg && !cmd_word.rx_line)
                        begin
                            mode_rx_next  = 1'b1;
                            rx_shift_next = 10'd0;
                            rx_left_next  = RX_FRAME_BITS;
                            tick_cnt_next = start_offset;
                        end
                        else if (!tx_stat.empty)
                        begin
                            tx_ctl.pop    = 1'b1;
                            tx_fill_next  = 1'b1;
                            line_out_next = 1'b0;
                            tx_left_next  = TX_SHIFT_BITS;
                            tick_cnt_next = bit_period;
                            mode_tx_next  = 1'b1;
                        end
                    end

                    last_rx_next = cmd_word.rx_line;
                end
                OP_PUSH:
                begin
                    if (!tx_stat.full)
                    begin
                        tx_ctl.push = 1'b1;
                        accepted    = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (!rx_stat.empty)
                    begin
                        rx_ctl.pop = 1'b1;
                        rx_got     = 1'b1;
                    end
                end
                OP_NOP:
                begin
                end
            endcase
        end
        rx_ctl.data = rx_shift_next[8:1];
    end

    // Queue fill after this command
    assign rx_cnt_post = rx_count + CW'(rx_ctl.push) - CW'(rx_ctl.pop);
    assign tx_cnt_post = tx_count + CW'(tx_ctl.push) - CW'(tx_ctl.pop);
    assign rx_cnt_wide = 32'(rx_cnt_post);
    assign tx_cnt_wide = 32'(tx_cnt_post);

    // Result word (received byte joins from the queue read register)
    always_comb
    begin
        res_next.tx_line      = line_out_next;
        res_next.rx_byte      = 8'h00;
        res_next.rx_valid     = rx_got;
        res_next.tx_accepted  = accepted;
        res_next.rx_overrun   = overrun;
        res_next.rx_waiting   = rx_cnt_wide[4:0];
        res_next.tx_pending   = tx_cnt_wide[4:0];
        res_next.receiving    = mode_rx_next;
        res_next.transmitting = mode_tx_next;
        out_valid_next        = fire ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_rx_reg   <= 1'b0;
            mode_tx_reg   <= 1'b0;
            line_out_reg  <= 1'b1;
            last_rx_reg   <= 1'b1;
            tick_cnt_reg  <= 16'd0;
            rx_left_reg   <= 4'd0;
            tx_left_reg   <= 4'd0;
            tx_fill_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_rx_reg   <= mode_rx_next;
            mode_tx_reg   <= mode_tx_next;
            line_out_reg  <= line_out_next;
            last_rx_reg   <= last_rx_next;
            tick_cnt_reg  <= tick_cnt_next;
            rx_left_reg   <= rx_left_next;
            tx_left_reg   <= tx_left_next;
            tx_fill_reg   <= tx_fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Shift registers and result payload
    always_ff @(posedge clk)
    begin
        rx_shift_reg <= rx_shift_next;
        tx_shift_reg <= tx_shift_next;
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // Output channel
    assign out_valid = out_valid_reg;
    always_comb
    begin
        out_data         = res_reg;
        out_data.rx_byte = res_reg.rx_valid ? rx_rd_data : 8'h00;
    end

    // Half duplex: never both directions at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_rx_reg && mode_tx_reg))
        else $error("receive and transmit active together");

    // A transmission always opens with the start bit on the line
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mode_tx_reg) |-> !line_out_reg)
        else $error("transmit started without a low start bit");

    // Receive bit counter stays within one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_rx_reg |-> (rx_left_reg != 4'd0 && rx_left_reg <= RX_FRAME_BITS))
        else $error("receive bit count out of frame");

    // Pending byte fetch only exists during a transmission
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_fill_reg |-> mode_tx_reg)
        else $error("transmit byte fetch outside a transmission");

endmodule

`default_nettype wire

// ===== rtl/core/half_duplex_uart_8n1_top.sv =====
// ============================================================================
// half_duplex_uart_8n1_top: half-duplex 8N1 UART
// Tick-driven serial transmitter and receiver with byte queues each way,
// a command intake queue, a result register and an APB register port.
// ============================================================================
// The block takes one word per clock while in_stall is low and returns
// exactly one result word per input word, in order. A word passes through
// a two-entry intake queue and the bit engine and appears in the result
// register; with no stall, words stream at one per cycle. Both byte queues
// sit in memories with a registered read port; the byte for a new
// transmission is read on the start-bit tick and loaded into the shifter on
// the next word.
// Program bit_period and start_offset only while no words are in flight.
`default_nettype none

module half_duplex_uart_8n1_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hdu_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Command channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire hdu_pkg::in_word_t             in_data,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output hdu_pkg::out_word_t                 out_data
);
    import hdu_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]   bit_period_reg;
    logic [15:0]   start_offset_reg;
    logic          reg_idx;
    logic          cfg_wr;

    logic          cmd_valid;
    cmd_word_t     cmd_word;
    logic          cmd_pop;
    q_ctl_t        tx_ctl;
    q_ctl_t        rx_ctl;
    logic [7:0]    tx_rd_data;
    logic [7:0]    rx_rd_data;
    logic [CW-1:0] tx_count;
    logic [CW-1:0] rx_count;
    q_stat_t       tx_stat;
    q_stat_t       rx_stat;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_BIT_PERIOD:   prdata = {16'h0000, bit_period_reg};
            REG_START_OFFSET: prdata = {16'h0000, start_offset_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg   <= RESET_BIT_PERIOD;
            start_offset_reg <= RESET_START_OFFSET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BIT_PERIOD:   bit_period_reg   <= pwdata[15:0];
                REG_START_OFFSET: start_offset_reg <= pwdata[15:0];
            endcase
        end
    end

    // Command intake
    hdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .cmd_pop   (cmd_pop)
    );

    // Bit engine
    hdu_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .bit_period   (bit_period_reg),
        .start_offset (start_offset_reg),
        .cmd_valid    (cmd_valid),
        .cmd_word     (cmd_word),
        .cmd_pop      (cmd_pop),
        .tx_ctl       (tx_ctl),
        .tx_rd_data   (tx_rd_data),
        .tx_count     (tx_count),
        .tx_stat      (tx_stat),
        .rx_ctl       (rx_ctl),
        .rx_rd_data   (rx_rd_data),
        .rx_count     (rx_count),
        .rx_stat      (rx_stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    // Transmit byte queue
    hdu_byte_q #(
        .DEPTH (QUEUE_DEPTH)
    ) u_tx_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tx_ctl),
        .rd_data (tx_rd_data),
        .count   (tx_count),
        .stat    (tx_stat)
    );

    // Receive byte queue
    hdu_byte_q #(
        .DEPTH (QUEUE_DEPTH)
    ) u_rx_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (rx_ctl),
        .rd_data (rx_rd_data),
        .count   (rx_count),
        .stat    (rx_stat)
    );

endmodule

`default_nettype wire

// ===== tb/half_duplex_uart_8n1_checker.sv =====
// ============================================================================
// half_duplex_uart_8n1_checker: result predictor and comparator
// Watches the register port, the command channel and the result channel.
// Each accepted command word is run through a cycle-free model of the UART
// (queues, bit timer, shifters, line state) to produce the expected result
// word. Each accepted result word is compared field by field with the
// oldest expected word.
// ============================================================================

module half_duplex_uart_8n1_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [hdu_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire hdu_pkg::in_word_t             in_data,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire hdu_pkg::out_word_t            out_data,
    output int                                 open_words,
    output int                                 fail_count
);

    import hdu_pkg::*;

    // Model state
    logic [7:0]  tx_mem [QUEUE_DEPTH];
    logic [7:0]  rx_mem [QUEUE_DEPTH];
    int          tx_head;
    int          tx_count;
    int          rx_head;
    int          rx_count;
    logic [9:0]  tx_sh;
    logic [3:0]  tx_bits;
    logic [9:0]  rx_sh;
    logic [3:0]  rx_bits;
    logic [15:0] tick_left;
    logic        busy_rx;
    logic        busy_tx;
    logic        line_q;
    logic        prev_line;
    logic [15:0] period_reg;
    logic [15:0] offset_reg;

    out_word_t   due_results[$];
    int          mismatches;

    // One timer tick with the sampled receive level
    task automatic uart_tick(input logic line, output logic overrun);
        logic was_idle;
        logic [7:0] b;
        begin
            overrun = 1'b0;
            was_idle = !busy_rx && !busy_tx;
            if (busy_rx)
            begin
                if (tick_left <= 16'd1)
                begin
                    rx_sh = {line, rx_sh[9:1]};
                    rx_bits = rx_bits - 4'd1;
                    tick_left = period_reg;
                    if (rx_bits == 4'd0)
                    begin
                        busy_rx = 1'b0;
                        tick_left = '0;
                        // keep only frames with low start and high stop
                        if (rx_sh[9] && !rx_sh[0])
                        begin
                            if (rx_count >= QUEUE_DEPTH)
                                overrun = 1'b1;
                            else
                            begin
                                rx_mem[(rx_head + rx_count) % QUEUE_DEPTH] = rx_sh[8:1];
                                rx_count++;
                            end
                        end
                    end
                end
                else
                    tick_left = tick_left - 16'd1;
            end
            else if (busy_tx)
            begin
                if (tick_left <= 16'd1)
                begin
                    if (tx_bits > 4'd0)
                    begin
                        line_q = tx_sh[0];
                        tx_sh = tx_sh >> 1;
                        tx_bits = tx_bits - 4'd1;
                        tick_left = period_reg;
                    end
                    else
                    begin
                        busy_tx = 1'b0;
                        line_q = 1'b1;
                        tick_left = '0;
                    end
                end
                else
                    tick_left = tick_left - 16'd1;
            end

            // From idle, a falling edge wins over a queued byte
            if (was_idle)
            begin
                if (prev_line && !line)
                begin
                    busy_rx = 1'b1;
                    rx_sh = '0;
                    rx_bits = RX_FRAME_BITS;
                    tick_left = offset_reg;
                end
                else if (tx_count > 0)
                begin
                    b = tx_mem[tx_head];
                    tx_head = (tx_head + 1) % QUEUE_DEPTH;
                    tx_count--;
                    tx_sh = {1'b1, b, 1'b0};
                    line_q = tx_sh[0];
                    tx_sh = tx_sh >> 1;
                    tx_bits = TX_SHIFT_BITS;
                    tick_left = period_reg;
                    busy_tx = 1'b1;
                end
            end
            prev_line = line;
        end
    endtask

    // Expected result word for one command word
    task automatic uart_step(input in_word_t w, output out_word_t r);
        logic ovr;
        begin
            r = '0;
            ovr = 1'b0;
            case (w.cmd)
                CMD_TICK:
                    uart_tick(w.rx_line, ovr);
                CMD_SEND:
                begin
                    if (tx_count < QUEUE_DEPTH)
                    begin
                        tx_mem[(tx_head + tx_count) % QUEUE_DEPTH] = w.tx_byte;
                        tx_count++;
                        r.tx_accepted = 1'b1;
                    end
                end
                CMD_TAKE:
                begin
                    if (rx_count > 0)
                    begin
                        r.rx_byte = rx_mem[rx_head];
                        r.rx_valid = 1'b1;
                        rx_head = (rx_head + 1) % QUEUE_DEPTH;
                        rx_count--;
                    end
                end
                default:
                    ;
            endcase
            r.tx_line = line_q;
            r.rx_overrun = ovr;
            r.rx_waiting = 5'(rx_count);
            r.tx_pending = 5'(tx_count);
            r.receiving = busy_rx;
            r.transmitting = busy_tx;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t predicted;
        if (!rst_n)
        begin
            tx_head = 0;
            tx_count = 0;
            rx_head = 0;
            rx_count = 0;
            tx_sh = '0;
            tx_bits = '0;
            rx_sh = '0;
            rx_bits = '0;
            tick_left = '0;
            busy_rx = 1'b0;
            busy_tx = 1'b0;
            line_q = 1'b1;
            prev_line = 1'b1;
            period_reg = RESET_BIT_PERIOD;
            offset_reg = RESET_START_OFFSET;
            due_results.delete();
            mismatches = 0;
            open_words <= 0;
            fail_count <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_BIT_PERIOD:   period_reg = pwdata[15:0];
                    REG_START_OFFSET: offset_reg = pwdata[15:0];
                    default:          ;
                endcase
            end

            // accepted command word
            if (in_valid && !in_stall)
            begin
                uart_step(in_data, predicted);
                due_results.push_back(predicted);
            end

            // accepted result word
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word arrived with no word pending");
                    mismatches++;
                end
                else
                begin
                    predicted = due_results.pop_front();
                    check_field("tx_line", predicted.tx_line, out_data.tx_line);
                    check_field("rx_byte", predicted.rx_byte, out_data.rx_byte);
                    check_field("rx_valid", predicted.rx_valid, out_data.rx_valid);
                    check_field("tx_accepted", predicted.tx_accepted, out_data.tx_accepted);
                    check_field("rx_overrun", predicted.rx_overrun, out_data.rx_overrun);
                    check_field("rx_waiting", predicted.rx_waiting, out_data.rx_waiting);
                    check_field("tx_pending", predicted.tx_pending, out_data.tx_pending);
                    check_field("receiving", predicted.receiving, out_data.receiving);
                    check_field("transmitting", predicted.transmitting,
                                out_data.transmitting);
                end
            end

            open_words <= due_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/half_duplex_uart_8n1_top_test.sv =====
// ============================================================================
// half_duplex_uart_8n1_top_test: stimulus and verdict for the 8N1 UART
// Drives a short directed sequence, then phases of random command words
// built around serial frames on the receive line (good frames, broken stop
// bits, glitches, noise) mixed with send, take and empty commands. Bit
// timing is reprogrammed between phases, the extremes included, and both
// channels idle or stall at random rates that change per phase.
// ============================================================================

module half_duplex_uart_8n1_top_test;

    import hdu_pkg::*;

    localparam int         QUEUE_DEPTH   = 16;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_data;

    int                   open_words;
    int                   fail_count;
    int                   cycle_count = 0;
    int                   stall_pct = 0;
    int                   gap_pct = 0;
    int unsigned          cur_period = RESET_BIT_PERIOD;
    bit                   line_plan[$];

    half_duplex_uart_8n1_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    half_duplex_uart_8n1_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) result_check (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .open_words(open_words),
        .fail_count(fail_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_t m);
        gap_pct = (m == IDLE_SENDER) ? 87 : (m == IDLE_BOTH) ? 12 : 0;
        stall_pct <= (m == IDLE_RECEIVER) ? 87 : (m == IDLE_BOTH) ? 12 : 0;
    endtask

    // Present one word and hold it until accepted; valid stays high after
    task automatic put_word(input in_word_t w);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic in_word_t word_of(input logic [1:0] cmd, input logic line,
                                         input logic [7:0] data);
        in_word_t w;
        w.cmd = cmd;
        w.rx_line = line;
        w.tx_byte = data;
        return w;
    endfunction

    task automatic write_reg(input logic idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all words in flight, then program the bit timing
    task automatic configure(input int unsigned period, input int unsigned offset);
        in_valid <= 1'b0;
        while (open_words != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_BIT_PERIOD, 16'(period));
        write_reg(REG_START_OFFSET, 16'(offset));
        cur_period = period;
    endtask

    function automatic void push_run(input bit level, input int count);
        for (int i = 0; i < count; i++)
            line_plan.push_back(level);
    endfunction

    // Append one stretch of receive line activity; long periods are scaled down
    function automatic void plan_line(input int pct_good);
        int unit;
        int r;
        bit [7:0] b;
        unit = (cur_period == 0) ? 1 : (cur_period > 64) ? 64 : int'(cur_period);
        r = $urandom_range(0, 99);
        if (r < pct_good + (100 - pct_good) / 2)
        begin
            // frame; the stop bit is broken outside the good share
            b = 8'($urandom_range(0, 255));
            push_run(1'b0, unit);
            for (int j = 0; j < 8; j++)
                push_run(b[j], unit);
            push_run(r < pct_good, unit);
            push_run(1'b1, $urandom_range(0, 2 * unit));
        end
        else if (r[0])
        begin
            // short low glitch
            push_run(1'b0, $urandom_range(1, unit));
            push_run(1'b1, $urandom_range(1, 3 * unit));
        end
        else
        begin
            // random noise, then back to mark
            repeat ($urandom_range(1, 4 * unit))
                line_plan.push_back(1'($urandom_range(0, 1)));
            push_run(1'b1, $urandom_range(1, 2 * unit));
        end
    endfunction

    function automatic bit next_level(input int pct_good);
        if (line_plan.size() == 0)
            plan_line(pct_good);
        return line_plan.pop_front();
    endfunction

    // Random command words; empty commands do not count toward n
    task automatic run_phase(input int n, input int pct_send, input int pct_take,
                             input int pct_good);
        int done;
        int r;
        in_word_t w;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(0, 99);
            w.rx_line = 1'($urandom_range(0, 1));
            w.tx_byte = 8'($urandom_range(0, 255));
            if (r < pct_send)
                w.cmd = CMD_SEND;
            else if (r < pct_send + pct_take)
                w.cmd = CMD_TAKE;
            else if (r < pct_send + pct_take + 2)
                w.cmd = CMD_NONE;
            else
            begin
                w.cmd = CMD_TICK;
                w.rx_line = next_level(pct_good);
            end
            put_word(w);
            if (w.cmd != CMD_NONE)
                done++;
        end
    endtask

    initial
    begin
        int bp;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty take, empty command, fill the send queue past full,
        // then a falling edge that must win over the queued bytes
        set_idle(IDLE_NONE);
        put_word(word_of(CMD_TAKE, 1'b1, 8'h00));
        put_word(word_of(CMD_NONE, 1'b0, 8'hA5));
        put_word(word_of(CMD_TICK, 1'b1, 8'h5A));
        put_word(word_of(CMD_SEND, 1'b1, 8'h00));
        put_word(word_of(CMD_SEND, 1'b0, 8'hFF));
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            put_word(word_of(CMD_SEND, 1'(k), 8'($urandom_range(0, 255))));
        put_word(word_of(CMD_TICK, 1'b0, 8'hFF));
        put_word(word_of(CMD_TAKE, 1'b0, 8'h00));
        put_word(word_of(CMD_TICK, 1'b0, 8'h00));
        put_word(word_of(CMD_TICK, 1'b1, 8'h00));

        // Shortest legal timing, mixed traffic
        configure(2, 1);
        set_idle(IDLE_SENDER);
        run_phase(180, 4, 6, 85);

        // No takes: receive queue fills and overruns
        set_idle(IDLE_RECEIVER);
        run_phase(500, 0, 0, 90);

        // Degenerate timer values, one tick each
        configure(1, 0);
        set_idle(IDLE_BOTH);
        run_phase(120, 8, 10, 60);

        // Random timing with sample point inside each bit
        for (int k = 0; k < 5; k++)
        begin
            bp = $urandom_range(3, 12);
            configure(bp, $urandom_range(1, bp - 1));
            set_idle(idle_mode_t'(k % 4));
            run_phase(90, $urandom_range(0, 15), $urandom_range(0, 20),
                      $urandom_range(50, 95));
        end

        // Longest timing; frames never complete within the run
        configure(16'hFFFF, 16'hFFFF);
        set_idle(IDLE_NONE);
        run_phase(60, 10, 10, 0);

        in_valid <= 1'b0;
        while (open_words != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hdu_pkg.sv
rtl/core/hdu_front.sv
rtl/core/hdu_byte_q.sv
rtl/core/hdu_engine.sv
rtl/core/half_duplex_uart_8n1_top.sv
tb/half_duplex_uart_8n1_checker.sv
tb/half_duplex_uart_8n1_top_test.sv
